// ----- hdl/point_in_quadrilateral_test_defines.svh -----
// Assertion macros shared by the point-in-quadrilateral RTL.
`ifndef POINT_IN_QUADRILATERAL_TEST_DEFINES_SVH
`define POINT_IN_QUADRILATERAL_TEST_DEFINES_SVH
// Asserts that a condition implies a consequence in the same cycle.
`define PIQ_ASSERT_IMP(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Asserts that a condition implies a consequence in the next cycle.
`define PIQ_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/piq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point-in-quadrilateral package
// Widths, result codes and the types passed between front and back.
// ----------------------------------------------------------------------------
package piq_pkg;
    localparam int CoordWidth = 24;
    localparam int FracBits   = 8;
    localparam int ThrWidth   = 24;
    localparam int ThrFrac    = 16;
    localparam int DiffWidth  = CoordWidth + 1;
    localparam int ProdWidth  = 2 * DiffWidth;
    localparam int CrossWidth = ProdWidth + 1;
    localparam int NumEdges   = 5;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    localparam logic [1:0] HOW_OUTSIDE = 2'd0;
    localparam logic [1:0] HOW_TRI1    = 2'd1;
    localparam logic [1:0] HOW_TRI2    = 2'd2;
    localparam logic [1:0] HOW_EDGE    = 2'd3;

    typedef logic signed [CoordWidth-1:0] t_coord;
    typedef logic signed [DiffWidth-1:0]  t_diff;
    typedef logic signed [CrossWidth-1:0] t_cross;

    // One edge after its cross product, ready for the tolerance tests.
    typedef struct packed {
        t_cross cr;
        t_diff  bay;
        t_diff  bax;
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_edge;

    // Word handed from the front to the back through the queue.
    typedef struct packed {
        logic [1:0]            tri_code;
        t_edge [NumEdges-1:0]  edges;
        t_coord                px;
        t_coord                py;
    } t_word;
endpackage
`default_nettype wire

// ----- hdl/piq_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point-in-quadrilateral front end
// Three-stage pipeline: differences, products, then triangle classification
// and edge cross products.
// ----------------------------------------------------------------------------
module piq_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire piq_pkg::t_coord  i_ax, i_ay, i_bx, i_by, i_cx, i_cy,
    input  wire piq_pkg::t_coord  i_dx, i_dy, i_px, i_py,
    output logic                  o_valid,
    output piq_pkg::t_word        o_word
);
    localparam int NP = 16;

    piq_pkg::t_diff  n_d [0:15];
    piq_pkg::t_diff  r_d [0:15];
    logic            r_v1, r_v2;
    piq_pkg::t_coord r1_c [0:9];
    piq_pkg::t_coord r2_c [0:9];
    piq_pkg::t_diff  r2_d [0:15];
    logic signed [piq_pkg::ProdWidth-1:0] r_p [0:NP-1];
    piq_pkg::t_coord ci [0:9];
    piq_pkg::t_word  n_word;

    function automatic piq_pkg::t_diff sub(piq_pkg::t_coord a, piq_pkg::t_coord b);
        return piq_pkg::t_diff'(a) - piq_pkg::t_diff'(b);
    endfunction

    function automatic logic tri_in(piq_pkg::t_cross d, piq_pkg::t_cross nu,
                                    piq_pkg::t_cross nv);
        piq_pkg::t_cross dd, uu, vv;
        logic signed [piq_pkg::CrossWidth:0] s;
        dd = d[piq_pkg::CrossWidth-1] ? -d : d;
        uu = d[piq_pkg::CrossWidth-1] ? -nu : nu;
        vv = d[piq_pkg::CrossWidth-1] ? -nv : nv;
        s = {uu[piq_pkg::CrossWidth-1], uu} + {vv[piq_pkg::CrossWidth-1], vv};
        return (d != '0) && !uu[piq_pkg::CrossWidth-1] && !vv[piq_pkg::CrossWidth-1]
            && (s < {dd[piq_pkg::CrossWidth-1], dd});
    endfunction

    function automatic piq_pkg::t_cross csub(logic signed [piq_pkg::ProdWidth-1:0] a,
                                             logic signed [piq_pkg::ProdWidth-1:0] b);
        return piq_pkg::t_cross'(a) - piq_pkg::t_cross'(b);
    endfunction

    assign ci = '{i_ax, i_ay, i_bx, i_by, i_cx, i_cy, i_dx, i_dy, i_px, i_py};

    always_comb begin
        // e0=A-B, e1=C-B, e2=D-B, p=P-B, then edge vectors pa and ba
        n_d[0]  = sub(i_ax, i_bx); n_d[1]  = sub(i_ay, i_by);
        n_d[2]  = sub(i_cx, i_bx); n_d[3]  = sub(i_cy, i_by);
        n_d[4]  = sub(i_dx, i_bx); n_d[5]  = sub(i_dy, i_by);
        n_d[6]  = sub(i_px, i_bx); n_d[7]  = sub(i_py, i_by);
        n_d[8]  = sub(i_px, i_ax); n_d[9]  = sub(i_py, i_ay);
        n_d[10] = sub(i_px, i_dx); n_d[11] = sub(i_py, i_dy);
        n_d[12] = sub(i_px, i_cx); n_d[13] = sub(i_py, i_cy);
        n_d[14] = sub(i_dx, i_cx); n_d[15] = sub(i_dy, i_cy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            o_valid <= r_v2;
        end
        r_d  <= n_d;
        r1_c <= ci;
        r2_c <= r1_c;
        r2_d <= r_d;
        o_word <= n_word;
        // Triangle products.
        r_p[0] <= r_d[2] * r_d[1];  r_p[1] <= r_d[3] * r_d[0];
        r_p[2] <= r_d[2] * r_d[7];  r_p[3] <= r_d[3] * r_d[6];
        r_p[4] <= r_d[6] * r_d[1];  r_p[5] <= r_d[7] * r_d[0];
        r_p[6] <= r_d[4] * r_d[3];  r_p[7] <= r_d[5] * r_d[2];
        r_p[8] <= r_d[4] * r_d[7];  r_p[9] <= r_d[5] * r_d[6];
        r_p[10] <= r_d[6] * r_d[3]; r_p[11] <= r_d[7] * r_d[2];
        // Edge products that are not shared with the triangle set.
        r_p[12] <= r_d[8] * r_d[1];  r_p[13] <= r_d[9] * r_d[0];
        r_p[14] <= r_d[10] * r_d[15]; r_p[15] <= r_d[11] * r_d[14];
    end

    // Remaining edge cross products use the per-edge multiply below.
    logic signed [piq_pkg::ProdWidth-1:0] r_q [0:5];
    always_ff @(posedge i_clk) begin
        // B-D edge: pa = P-B, ba = D-B
        r_q[0] <= r_d[6] * r_d[5];  r_q[1] <= r_d[7] * r_d[4];
        // C-A edge: pa = P-C, ba = A-C = e0-e1
        r_q[2] <= r_d[12] * (r_d[1] - r_d[3]);
        r_q[3] <= r_d[13] * (r_d[0] - r_d[2]);
        // B-C edge: pa = P-B, ba = C-B
        r_q[4] <= r_d[6] * r_d[3];  r_q[5] <= r_d[7] * r_d[2];
    end

    piq_pkg::t_diff cax, cay;
    always_comb begin
        cax = r2_c[0] - r2_c[4];
        cay = r2_c[1] - r2_c[5];
        n_word.px = r2_c[8];
        n_word.py = r2_c[9];
        if (tri_in(csub(r_p[0], r_p[1]), csub(r_p[2], r_p[3]), csub(r_p[4], r_p[5])))
            n_word.tri_code = piq_pkg::HOW_TRI1;
        else if (tri_in(csub(r_p[6], r_p[7]), csub(r_p[8], r_p[9]),
                        csub(r_p[10], r_p[11])))
            n_word.tri_code = piq_pkg::HOW_TRI2;
        else
            n_word.tri_code = piq_pkg::HOW_OUTSIDE;
        // A-B: pa = P-A, ba = B-A = -e0
        n_word.edges[0] = '{cr: csub(r_p[13], r_p[12]), bax: -r2_d[0], bay: -r2_d[1],
                           ax: r2_c[0], ay: r2_c[1], bx: r2_c[2], by: r2_c[3]};
        n_word.edges[1] = '{cr: csub(r_q[0], r_q[1]), bax: r2_d[4], bay: r2_d[5],
                           ax: r2_c[2], ay: r2_c[3], bx: r2_c[6], by: r2_c[7]};
        // D-C: pa = P-D, ba = C-D = -(D-C)
        n_word.edges[2] = '{cr: csub(r_p[15], r_p[14]), bax: -r2_d[14], bay: -r2_d[15],
                           ax: r2_c[6], ay: r2_c[7], bx: r2_c[4], by: r2_c[5]};
        n_word.edges[3] = '{cr: csub(r_q[2], r_q[3]), bax: cax, bay: cay,
                           ax: r2_c[4], ay: r2_c[5], bx: r2_c[0], by: r2_c[1]};
        n_word.edges[4] = '{cr: csub(r_q[4], r_q[5]), bax: r2_d[2], bay: r2_d[3],
                           ax: r2_c[2], ay: r2_c[3], bx: r2_c[4], by: r2_c[5]};
    end
endmodule
`default_nettype wire

// ----- hdl/piq_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point-in-quadrilateral word queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module piq_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire piq_pkg::t_word  i_word,
    input  wire logic            i_pop,
    output logic                 o_nonempty,
    output piq_pkg::t_word       o_word
);
    piq_pkg::t_word r_mem [0:piq_pkg::QueueDepth-1];
    logic [piq_pkg::QueuePtrW-1:0] r_wp, r_rp;
    logic [piq_pkg::QueuePtrW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_word;
    end

    assign o_nonempty = (r_cnt != '0);
    assign o_word = r_mem[r_rp];
endmodule
`default_nettype wire

// ----- hdl/piq_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point-in-quadrilateral back end
// Applies the edge tolerance and extent tests and registers the result.
// ----------------------------------------------------------------------------
`include "point_in_quadrilateral_test_defines.svh"
module piq_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire piq_pkg::t_word                i_word,
    input  wire logic [piq_pkg::ThrWidth-1:0]  i_thr,
    output logic                               o_strobe,
    output logic                               o_inside,
    output logic [1:0]                         o_how
);
    localparam int S = 2 * piq_pkg::FracBits - piq_pkg::ThrFrac;
    localparam int CW = piq_pkg::CrossWidth + 40;

    function automatic logic on_edge(piq_pkg::t_edge e, piq_pkg::t_coord px,
                                     piq_pkg::t_coord py,
                                     logic [piq_pkg::ThrWidth-1:0] thr);
        logic [CW-1:0] c, t;
        logic [CW-1:0] lhs, rhs;
        logic in_x, in_y;
        c = CW'(e.cr[piq_pkg::CrossWidth-1] ? -e.cr : e.cr);
        t = CW'(thr);
        if (S >= 0) t = t << S; else c = c << (-S);
        lhs = CW'(e.bay[piq_pkg::DiffWidth-1] ? -e.bay : e.bay) << piq_pkg::ThrFrac;
        rhs = CW'(thr) << piq_pkg::FracBits;
        in_x = (e.bax > 0) ? (e.ax <= px && px <= e.bx) : (e.bx <= px && px <= e.ax);
        in_y = (e.bay > 0) ? (e.ay <= py && py <= e.by) : (e.by <= py && py <= e.ay);
        return (c <= t) && ((lhs < rhs) ? in_x : in_y);
    endfunction

    logic [piq_pkg::NumEdges-1:0] hits;
    always_comb begin
        for (int k = 0; k < piq_pkg::NumEdges; k++)
            hits[k] = on_edge(i_word.edges[k], i_word.px, i_word.py, i_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_valid;
        end
        if (i_word.tri_code != piq_pkg::HOW_OUTSIDE) o_how <= i_word.tri_code;
        else if (hits != '0) o_how <= piq_pkg::HOW_EDGE;
        else o_how <= piq_pkg::HOW_OUTSIDE;
        o_inside <= (i_word.tri_code != piq_pkg::HOW_OUTSIDE) || (hits != '0);
    end

    `PIQ_ASSERT_IMP(a_inside_code, i_clk, i_rst_n, o_strobe, o_inside == (o_how != piq_pkg::HOW_OUTSIDE))
    `PIQ_ASSERT_NEXT(a_strobe_follows, i_clk, i_rst_n, i_valid, o_strobe)
    `PIQ_ASSERT_NEXT(a_tri_kept, i_clk, i_rst_n, i_valid && i_word.tri_code == piq_pkg::HOW_TRI1, o_how == piq_pkg::HOW_TRI1)
endmodule
`default_nettype wire

// ----- hdl/point_in_quadrilateral_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point-in-quadrilateral test
// Takes one query per cycle; each result appears with o_strobe after passing
// the three register stages of the front end, the queue register and the
// registered edge tests. The receiver cannot stall, so busy stays low and a
// word goes out every cycle one came in.
// ----------------------------------------------------------------------------
`include "point_in_quadrilateral_test_defines.svh"
module point_in_quadrilateral_test (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] cfg_data,
    input  wire logic signed [23:0] i_corner_a_x, i_corner_a_y,
    input  wire logic signed [23:0] i_corner_b_x, i_corner_b_y,
    input  wire logic signed [23:0] i_corner_c_x, i_corner_c_y,
    input  wire logic signed [23:0] i_corner_d_x, i_corner_d_y,
    input  wire logic signed [23:0] i_query_x, i_query_y,
    output logic             o_strobe,
    output logic             o_inside_res,
    output logic [1:0]       o_how_found
);
    logic [piq_pkg::ThrWidth-1:0] r_thr;
    logic f_valid, q_ne;
    piq_pkg::t_word f_word, q_word;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thr <= 24'd66;
        else if (cfg_valid && cfg_ready) r_thr <= cfg_data;
    end

    piq_front u_front (
        .i_clk, .i_rst_n, .i_valid(start && !busy),
        .i_ax(i_corner_a_x), .i_ay(i_corner_a_y), .i_bx(i_corner_b_x), .i_by(i_corner_b_y),
        .i_cx(i_corner_c_x), .i_cy(i_corner_c_y), .i_dx(i_corner_d_x), .i_dy(i_corner_d_y),
        .i_px(i_query_x), .i_py(i_query_y), .o_valid(f_valid), .o_word(f_word)
    );

    piq_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_word(f_word), .i_pop(q_ne),
        .o_nonempty(q_ne), .o_word(q_word)
    );

    piq_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_ne), .i_word(q_word), .i_thr(r_thr),
        .o_strobe, .o_inside(o_inside_res), .o_how(o_how_found)
    );

    `PIQ_ASSERT_IMP(a_no_busy, i_clk, i_rst_n, 1'b1, !busy)
    `PIQ_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, cfg_valid, cfg_ready)
    `PIQ_ASSERT_IMP(a_strobe_inside, i_clk, i_rst_n, o_strobe && o_inside_res, o_how_found != piq_pkg::HOW_OUTSIDE)
endmodule
`default_nettype wire

// ----- bench/point_in_quadrilateral_test_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-quadrilateral test bench
// Drives corner sets and query points through the query inputs, works out
// the expected inside flag and finding code with exact integer arithmetic,
// and compares every strobed result in order across several edge tolerances.
// ----------------------------------------------------------------------------
module point_in_quadrilateral_test_test;
    localparam int LIMIT = 400000;

    typedef struct {
        piq_pkg::t_coord ax, ay, bx, by, cx, cy, dx, dy, qx, qy;
    } t_query;

    typedef struct {
        logic       in_quad;
        logic [1:0] how;
    } t_verdict;

    class quad_scoreboard;
        logic [23:0] threshold = 24'd66;
        t_verdict    pending[$];
        int          errors = 0;

        function longint cross2(longint ux, longint uy, longint vx, longint vy);
            return ux * vy - uy * vx;
        endfunction

        function bit in_triangle(longint e0x, longint e0y, longint e1x, longint e1y,
                                 longint px, longint py);
            longint d, nu, nv;
            d  = cross2(e1x, e1y, e0x, e0y);
            nu = cross2(e1x, e1y, px, py);
            nv = cross2(px, py, e0x, e0y);
            if (d == 0) return 1'b0;
            if (d < 0) begin
                d = -d;
                nu = -nu;
                nv = -nv;
            end
            return nu >= 0 && nv >= 0 && nu + nv < d;
        endfunction

        function bit on_edge(longint ax, longint ay, longint bx, longint by,
                             longint px, longint py);
            longint c, bax, bay, lhs, rhs;
            bax = bx - ax;
            bay = by - ay;
            c = cross2(px - ax, py - ay, bax, bay);
            if (c < 0) c = -c;
            if (c > longint'(threshold)) return 1'b0;
            lhs = (bay < 0 ? -bay : bay) <<< 16;
            rhs = longint'(threshold) <<< 8;
            if (lhs < rhs)
                return bax > 0 ? (ax <= px && px <= bx) : (bx <= px && px <= ax);
            return bay > 0 ? (ay <= py && py <= by) : (by <= py && py <= ay);
        endfunction

        function void note(t_query q);
            t_verdict v;
            v.how = piq_pkg::HOW_OUTSIDE;
            if (in_triangle(q.ax - q.bx, q.ay - q.by, q.cx - q.bx, q.cy - q.by,
                            q.qx - q.bx, q.qy - q.by))
                v.how = piq_pkg::HOW_TRI1;
            else if (in_triangle(q.cx - q.bx, q.cy - q.by, q.dx - q.bx, q.dy - q.by,
                                 q.qx - q.bx, q.qy - q.by))
                v.how = piq_pkg::HOW_TRI2;
            else if (on_edge(q.ax, q.ay, q.bx, q.by, q.qx, q.qy) ||
                     on_edge(q.bx, q.by, q.dx, q.dy, q.qx, q.qy) ||
                     on_edge(q.dx, q.dy, q.cx, q.cy, q.qx, q.qy) ||
                     on_edge(q.cx, q.cy, q.ax, q.ay, q.qx, q.qy) ||
                     on_edge(q.bx, q.by, q.cx, q.cy, q.qx, q.qy))
                v.how = piq_pkg::HOW_EDGE;
            v.in_quad = v.how != piq_pkg::HOW_OUTSIDE;
            pending.push_back(v);
        endfunction

        function void check(logic res_in, logic [1:0] how);
            t_verdict v;
            if (pending.size() == 0) begin
                $error("unexpected result word: inside_res %0d how_found %0d", res_in, how);
                errors++;
                return;
            end
            v = pending.pop_front();
            if (res_in !== v.in_quad) begin
                $error("inside_res: expected %0d, actual %0d", v.in_quad, res_in);
                errors++;
            end
            if (how !== v.how) begin
                $error("how_found: expected %0d, actual %0d", v.how, how);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = '0;
    t_query      drv = '{default: '0};
    logic        o_strobe, o_inside_res;
    logic [1:0]  o_how_found;
    int          cycles = 0;
    quad_scoreboard sb = new();

    point_in_quadrilateral_test u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .i_corner_a_x(drv.ax), .i_corner_a_y(drv.ay),
        .i_corner_b_x(drv.bx), .i_corner_b_y(drv.by),
        .i_corner_c_x(drv.cx), .i_corner_c_y(drv.cy),
        .i_corner_d_x(drv.dx), .i_corner_d_y(drv.dy),
        .i_query_x(drv.qx), .i_query_y(drv.qy),
        .o_strobe(o_strobe), .o_inside_res(o_inside_res), .o_how_found(o_how_found)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_strobe) sb.check(o_inside_res, o_how_found);
        if (cycles > LIMIT) begin
            $display("point_in_quadrilateral_test: mismatch");
            $finish;
        end
    end

    task automatic send_query(t_query q);
        @(negedge i_clk);
        drv = q;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note(q);
    endtask

    task automatic idle(int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        idle(0);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [23:0] value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        sb.threshold = value;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic t_query square_query(piq_pkg::t_coord x, piq_pkg::t_coord y);
        t_query q;
        q = '{ax: 0, ay: 0, bx: 0, by: 1024, cx: 1024, cy: 0, dx: 1024, dy: 1024,
              qx: x, qy: y};
        return q;
    endfunction

    function automatic piq_pkg::t_coord near(piq_pkg::t_coord base, int span);
        return base + piq_pkg::t_coord'($urandom_range(2 * span) - span);
    endfunction

    function automatic t_query random_query();
        t_query q;
        piq_pkg::t_coord ox, oy;
        int size, mode;
        mode = $urandom_range(99);
        if (mode < 15) begin
            q = '{ax: $urandom, ay: $urandom, bx: $urandom, by: $urandom,
                  cx: $urandom, cy: $urandom, dx: $urandom, dy: $urandom,
                  qx: $urandom, qy: $urandom};
            return q;
        end
        size = ($urandom_range(3) == 0) ? $urandom_range(1, 1 << 20)
                                        : $urandom_range(1, 2048);
        ox = near(0, 1 << 21);
        oy = near(0, 1 << 21);
        q.ax = near(ox, size / 8);         q.ay = near(oy, size / 8);
        q.bx = near(ox, size / 8);         q.by = near(oy + size, size / 8);
        q.cx = near(ox + size, size / 8);  q.cy = near(oy, size / 8);
        q.dx = near(ox + size, size / 8);  q.dy = near(oy + size, size / 8);
        case ($urandom_range(5))
            0: begin q.qx = q.ax; q.qy = q.ay; end
            1: begin q.qx = (q.ax + q.bx) >>> 1; q.qy = (q.ay + q.by) >>> 1; end
            2: begin q.qx = (q.bx + q.cx) >>> 1; q.qy = (q.by + q.cy) >>> 1; end
            3: begin q.qx = near(q.dx, 2); q.qy = near(q.dy, 2); end
            4: begin
                q.cx = q.bx + (q.bx - q.ax);
                q.cy = q.by + (q.by - q.ay);
                q.qx = near(ox + size / 2, size);
                q.qy = near(oy + size / 2, size);
            end
            default: begin
                q.qx = near(ox + size / 2, size);
                q.qy = near(oy + size / 2, size);
            end
        endcase
        return q;
    endfunction

    task automatic random_phase(int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < n; k++) begin
                send_query(random_query());
                sent++;
            end
            if ($urandom_range(3) != 0) idle($urandom_range(1, 8));
            if (sent == n / 2) drain();
        end
    endtask

    initial begin
        logic [23:0] settings[5];
        t_query q;
        settings = '{24'd0, 24'hFFFFFF, 24'd66, 24'd256, 24'd0};
        settings[4] = $urandom;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_query(square_query(100, 100));
        send_query(square_query(900, 900));
        send_query(square_query(512, 512));
        send_query(square_query(0, 500));
        send_query(square_query(1024, 300));
        send_query(square_query(2000, 2000));
        send_query(square_query(-1, 0));
        send_query(square_query(0, 0));
        send_query(square_query(1024, 1024));
        q = '{ax: 0, ay: 0, bx: 100, by: 100, cx: 200, cy: 200, dx: 300, dy: 300,
              qx: 150, qy: 150};
        send_query(q);
        q.qx = 150; q.qy = 151;
        send_query(q);
        q = '{default: 24'sh7FFFFF};
        send_query(q);
        q = '{default: -24'sh800000};
        send_query(q);
        q = '{ax: -24'sh800000, ay: -24'sh800000, bx: -24'sh800000, by: 24'sh7FFFFF,
              cx: 24'sh7FFFFF, cy: -24'sh800000, dx: 24'sh7FFFFF, dy: 24'sh7FFFFF,
              qx: 0, qy: 0};
        send_query(q);
        q.qx = 24'sh7FFFFF; q.qy = 24'sh7FFFFF;
        send_query(q);
        q.qx = -24'sh800000; q.qy = 0;
        send_query(q);
        q = '{default: 24'sd5};
        send_query(q);
        drain();
        write_threshold(24'd0);
        q = '{default: 24'sd5};
        send_query(q);
        send_query(square_query(0, 500));
        drain();

        foreach (settings[i]) begin
            write_threshold(settings[i]);
            random_phase(250);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("point_in_quadrilateral_test: match");
        else
            $display("point_in_quadrilateral_test: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/piq_pkg.sv
hdl/piq_front.sv
hdl/piq_queue.sv
hdl/piq_back.sv
hdl/point_in_quadrilateral_test.sv
bench/point_in_quadrilateral_test_test.sv
